// File: rtl/core/ptp_pkg.sv
// Package for the period timer: item codes, decoded command, queue status.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ptp_pkg;

  localparam int unsigned PRESCALE_DIV_DEF = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned HLD_IDX = 7;
  localparam int unsigned GO_IDX = 6;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    SEL_CTRL   = 2'd0,
    SEL_PERIOD = 2'd1,
    SEL_COUNT  = 2'd2
  } reg_sel_e;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_READ,
    CMD_WRITE
  } cmd_kind_e;

  typedef enum logic [1:0] {
    REG_NONE,
    REG_CTRL,
    REG_PERIOD,
    REG_COUNT
  } reg_id_e;

  typedef struct packed {
    cmd_kind_e          kind;
    reg_id_e            target;
    logic [DATA_W-1:0]  data;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

endpackage

`default_nettype wire

// File: rtl/core/ptp_front.sv
// Front end of the period timer: classifies each input beat into a command.
// Depends on ptp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptp_front (
  input  wire logic [1:0]                  action_i,
  input  wire logic [1:0]                  reg_select_i,
  input  wire logic [ptp_pkg::DATA_W-1:0]  write_data_i,
  output ptp_pkg::cmd_t                    cmd_o
);

  ptp_pkg::reg_id_e target;

  always_comb begin
    unique case (reg_select_i)
      ptp_pkg::SEL_CTRL:   target = ptp_pkg::REG_CTRL;
      ptp_pkg::SEL_PERIOD: target = ptp_pkg::REG_PERIOD;
      ptp_pkg::SEL_COUNT:  target = ptp_pkg::REG_COUNT;
      default:             target = ptp_pkg::REG_NONE;
    endcase
  end

  always_comb begin
    cmd_o.data   = write_data_i;
    cmd_o.target = target;
    unique case (action_i)
      ptp_pkg::ACT_TICK:  cmd_o.kind = ptp_pkg::CMD_TICK;
      ptp_pkg::ACT_READ:  cmd_o.kind = ptp_pkg::CMD_READ;
      ptp_pkg::ACT_WRITE: cmd_o.kind = ptp_pkg::CMD_WRITE;
      default:            cmd_o.kind = ptp_pkg::CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/ptp_queue.sv
// Short command queue between the front and back of the period timer.
// Depends on ptp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ptp_pkg::cmd_t     push_cmd_i,
  input  wire logic              pop_i,
  output ptp_pkg::cmd_t          pop_cmd_o,
  output ptp_pkg::queue_status_t status_o
);

  ptp_pkg::cmd_t                  mem_q [ptp_pkg::QUEUE_DEPTH];
  logic [ptp_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ptp_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ptp_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                           do_push, do_pop;

  function automatic logic [ptp_pkg::QPTR_W-1:0] ptr_next(
    input logic [ptp_pkg::QPTR_W-1:0] p
  );
    if (p == ptp_pkg::QPTR_W'(ptp_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + ptp_pkg::QPTR_W'(1);
  endfunction

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  assign status_o.full  = (cnt_q == ptp_pkg::QCNT_W'(ptp_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign status_o.count = cnt_q;
  assign pop_cmd_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + ptp_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - ptp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ptp_back.sv
// Back end of the period timer: register file, prescaler, counter, result register.
// Depends on ptp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptp_back #(
  parameter int unsigned PRESCALE_DIV = ptp_pkg::PRESCALE_DIV_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  input  wire ptp_pkg::cmd_t               cmd_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ptp_pkg::DATA_W-1:0]       read_data_o,
  output logic                             period_event_o
);

  localparam int unsigned PW = $clog2(PRESCALE_DIV + 1);
  localparam logic [PW-1:0] PreDiv = PW'(PRESCALE_DIV);

  logic [ptp_pkg::DATA_W-1:0] ctrl_q, ctrl_d;
  logic [ptp_pkg::DATA_W-1:0] period_q, period_d;
  logic [ptp_pkg::DATA_W-1:0] count_q, count_d;
  logic [PW-1:0]              pre_q, pre_d;
  logic                       restart_q, restart_d;
  logic                       out_valid_q;
  logic [ptp_pkg::DATA_W-1:0] rdata_q, rdata_d;
  logic                       event_q, event_d;

  logic [ptp_pkg::DATA_W-1:0] cnt_base, cnt_inc;
  logic [PW-1:0]              pre_base, pre_inc;

  assign cmd_pop_o      = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o    = out_valid_q;
  assign read_data_o    = rdata_q;
  assign period_event_o = event_q;

  assign cnt_base = restart_q ? '0 : count_q;
  assign pre_base = restart_q ? '0 : pre_q;
  assign cnt_inc  = cnt_base + ptp_pkg::DATA_W'(1);
  assign pre_inc  = pre_base + PW'(1);

  always_comb begin
    ctrl_d    = ctrl_q;
    period_d  = period_q;
    count_d   = count_q;
    pre_d     = pre_q;
    restart_d = restart_q;
    rdata_d   = '0;
    event_d   = 1'b0;
    unique case (cmd_i.kind)
      ptp_pkg::CMD_TICK: begin
        if (ctrl_q[ptp_pkg::HLD_IDX]) begin
          restart_d = ctrl_q[ptp_pkg::GO_IDX];
          ctrl_d[ptp_pkg::GO_IDX] = 1'b0;
          if (pre_inc >= PreDiv) begin
            pre_d = '0;
            if (cnt_inc == period_q) begin
              count_d = '0;
              event_d = 1'b1;
            end else begin
              count_d = cnt_inc;
            end
          end else begin
            pre_d   = pre_inc;
            count_d = cnt_base;
          end
        end
      end
      ptp_pkg::CMD_READ: begin
        unique case (cmd_i.target)
          ptp_pkg::REG_CTRL:   rdata_d = ctrl_q;
          ptp_pkg::REG_PERIOD: rdata_d = period_q;
          ptp_pkg::REG_COUNT:  rdata_d = count_q;
          default:             rdata_d = '0;
        endcase
      end
      ptp_pkg::CMD_WRITE: begin
        unique case (cmd_i.target)
          ptp_pkg::REG_CTRL:   ctrl_d   = cmd_i.data;
          ptp_pkg::REG_PERIOD: period_d = cmd_i.data;
          ptp_pkg::REG_COUNT:  count_d  = cmd_i.data;
          default:             ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      period_q    <= '0;
      count_q     <= '0;
      pre_q       <= '0;
      restart_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        ctrl_q    <= ctrl_d;
        period_q  <= period_d;
        count_q   <= count_d;
        pre_q     <= pre_d;
        restart_q <= restart_d;
      end
      if (cmd_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      rdata_q <= rdata_d;
      event_q <= event_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/period_timer_with_prescale.sv
// Top level of the period timer: front decode, command queue, back execution.
// Depends on ptp_pkg, ptp_front, ptp_queue and ptp_back.
`timescale 1ns / 1ps
`default_nettype none

// Memory-mapped 32-bit period timer. Each input beat is a tick, a register
// read, a register write or a no-op; each gives exactly one result beat.
// A beat is decoded at the input, held in a two-entry command queue, and
// executed by the back end, whose result register is the output stage; one
// beat per clock is sustained while out_ready_i is high. Ticks count only
// while control bit 7 is set; bit 6 clears itself on the next enabled tick,
// and count and prescaler restart from zero on the enabled tick after that.
// The count advances every PRESCALE_DIV enabled ticks and wraps to zero with
// period_event_o when it reaches the period register.
module period_timer_with_prescale #(
  parameter int unsigned PRESCALE_DIV = ptp_pkg::PRESCALE_DIV_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  action_i,
  input  wire logic [1:0]                  reg_select_i,
  input  wire logic [ptp_pkg::DATA_W-1:0]  write_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ptp_pkg::DATA_W-1:0]       read_data_o,
  output logic                             period_event_o
);

  ptp_pkg::cmd_t          front_cmd;
  ptp_pkg::cmd_t          queue_cmd;
  ptp_pkg::queue_status_t queue_status;
  logic                   queue_pop;

  assign in_ready_o = !queue_status.full;

  ptp_front u_front (
    .action_i     (action_i),
    .reg_select_i (reg_select_i),
    .write_data_i (write_data_i),
    .cmd_o        (front_cmd)
  );

  ptp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_cmd_i (front_cmd),
    .pop_i      (queue_pop),
    .pop_cmd_o  (queue_cmd),
    .status_o   (queue_status)
  );

  ptp_back #(
    .PRESCALE_DIV (PRESCALE_DIV)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (!queue_status.empty),
    .cmd_i          (queue_cmd),
    .cmd_pop_o      (queue_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .period_event_o (period_event_o)
  );

`ifndef NO_ASSERTIONS
  a_event_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && period_event_o |-> read_data_o == '0)
    else $error("event beat carries read data");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_status.count <= ptp_pkg::QCNT_W'(ptp_pkg::QUEUE_DEPTH))
    else $error("command queue over depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_status.empty |-> !queue_pop)
    else $error("pop from empty command queue");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !queue_pop |=> !queue_status.empty)
    else $error("accepted beat lost before the back end");
`endif

endmodule

`default_nettype wire

// File: bench/period_timer_with_prescale_tb.sv
// Self-checking bench for period_timer_with_prescale: directed rows, then random
// timer episodes, checked beat by beat against an in-bench timer model.
// Depends on ptp_pkg and the period_timer_with_prescale RTL.
`timescale 1ns / 1ps

module period_timer_with_prescale_tb;

  localparam int unsigned DIV = ptp_pkg::PRESCALE_DIV_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] SEL_UNUSED = 2'd3;
  localparam int unsigned RANDOM_BEATS = 800;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned N_DIR = 23;

  typedef struct {
    logic [31:0] ctrl;
    logic [31:0] period;
    logic [31:0] count;
    int unsigned presc;
    bit          restart;
  } timer_state_t;

  typedef struct packed {
    logic [31:0] rd;
    logic        ev;
  } timer_out_t;

  typedef struct packed {
    logic [1:0]  act;
    logic [1:0]  sel;
    logic [31:0] data;
    logic [7:0]  reps;
    logic        typed;
    logic [31:0] rd;
    logic        ev;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [1:0]  reg_select_i = '0;
  logic [31:0] write_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] read_data_o;
  logic        period_event_o;

  timer_state_t tmr;
  timer_out_t   due_out_q[$];
  dir_row_t     dir_rows [N_DIR];

  int unsigned burst_left = 0;
  int unsigned live_beats = 0;
  int unsigned all_beats = 0;
  int unsigned checked = 0;
  int unsigned events_seen = 0;
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned run_left = 0;
  bit          rdy_lvl = 1'b0;

  period_timer_with_prescale u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .reg_select_i   (reg_select_i),
    .write_data_i   (write_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .period_event_o (period_event_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void timer_step(input logic [1:0] act, input logic [1:0] sel,
                                     input logic [31:0] data, output logic [31:0] rd,
                                     output logic ev);
    rd = '0;
    ev = 1'b0;
    case (act)
      ptp_pkg::ACT_TICK: begin
        if (tmr.ctrl[ptp_pkg::HLD_IDX]) begin
          if (tmr.restart) begin
            tmr.presc = 0;
            tmr.count = '0;
            tmr.restart = 1'b0;
          end
          if (tmr.ctrl[ptp_pkg::GO_IDX]) begin
            tmr.restart = 1'b1;
            tmr.ctrl[ptp_pkg::GO_IDX] = 1'b0;
          end
          tmr.presc++;
          if (tmr.presc >= DIV) begin
            tmr.presc = 0;
            tmr.count = tmr.count + 32'd1;
            if (tmr.count == tmr.period) begin
              tmr.count = '0;
              ev = 1'b1;
            end
          end
        end
      end
      ptp_pkg::ACT_READ: begin
        case (sel)
          ptp_pkg::SEL_CTRL:   rd = tmr.ctrl;
          ptp_pkg::SEL_PERIOD: rd = tmr.period;
          ptp_pkg::SEL_COUNT:  rd = tmr.count;
          default:             rd = '0;
        endcase
      end
      ptp_pkg::ACT_WRITE: begin
        case (sel)
          ptp_pkg::SEL_CTRL:   tmr.ctrl = data;
          ptp_pkg::SEL_PERIOD: tmr.period = data;
          ptp_pkg::SEL_COUNT:  tmr.count = data;
          default:             ;
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] ctrl_word();
    logic [31:0] w;
    w = $urandom;
    w[ptp_pkg::HLD_IDX] = ($urandom_range(0, 9) != 0);
    w[ptp_pkg::GO_IDX] = ($urandom_range(0, 2) == 0);
    return w;
  endfunction

  task automatic send_beat(input logic [1:0] act, input logic [1:0] sel,
                           input logic [31:0] data, input logic typed,
                           input logic [31:0] t_rd, input logic t_ev);
    int unsigned gap;
    logic [31:0] rd;
    logic        ev;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    action_i     <= act;
    reg_select_i <= sel;
    write_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    timer_step(act, sel, data, rd, ev);
    if (typed) begin
      rd = t_rd;
      ev = t_ev;
    end
    due_out_q.push_back('{rd: rd, ev: ev});
    all_beats++;
    if (act != ACT_UNUSED && !(act == ptp_pkg::ACT_WRITE && sel == SEL_UNUSED)) live_beats++;
  endtask

  task automatic send_body_beat();
    int unsigned pick;
    logic [1:0]  sel;
    logic [31:0] d;
    pick = $urandom_range(0, 99);
    sel = 2'($urandom_range(0, 3));
    d = $urandom;
    if (pick < 70) begin
      send_beat(ptp_pkg::ACT_TICK, sel, d, 1'b0, '0, 1'b0);
    end else if (pick < 82) begin
      send_beat(ptp_pkg::ACT_READ, sel, d, 1'b0, '0, 1'b0);
    end else if (pick < 95) begin
      if (sel == ptp_pkg::SEL_CTRL) d = ctrl_word();
      else if ($urandom_range(0, 1) == 0) d = $urandom_range(0, 6);
      send_beat(ptp_pkg::ACT_WRITE, sel, d, 1'b0, '0, 1'b0);
    end else begin
      send_beat(ACT_UNUSED, sel, d, 1'b0, '0, 1'b0);
    end
  endtask

  task automatic run_episode();
    int unsigned pick;
    logic [31:0] d;
    pick = $urandom_range(0, 9);
    if (pick < 6) d = $urandom_range(1, 4);
    else if (pick < 8) d = '0;
    else d = $urandom;
    send_beat(ptp_pkg::ACT_WRITE, ptp_pkg::SEL_PERIOD, d, 1'b0, '0, 1'b0);
    pick = $urandom_range(0, 9);
    if (pick < 5) d = $urandom_range(0, 3);
    else if (pick < 8) d = 32'hFFFF_FFFF - $urandom_range(0, 2);
    else d = $urandom;
    send_beat(ptp_pkg::ACT_WRITE, ptp_pkg::SEL_COUNT, d, 1'b0, '0, 1'b0);
    send_beat(ptp_pkg::ACT_WRITE, ptp_pkg::SEL_CTRL, ctrl_word(), 1'b0, '0, 1'b0);
    repeat ($urandom_range(10, 60)) send_body_beat();
  endtask

  // Check result beats and pace out_ready_i.
  always @(posedge clk_i) begin
    timer_out_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_out_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("result beat with nothing due: rd=%h ev=%b",
                                      read_data_o, period_event_o);
        end else begin
          e = due_out_q.pop_front();
          checked++;
          if (period_event_o === 1'b1) events_seen++;
          if (read_data_o !== e.rd || period_event_o !== e.ev) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch at result %0d: rd exp %h got %h, ev exp %b got %b",
                       checked, e.rd, read_data_o, e.ev, period_event_o);
            end
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          rdy_lvl = ($urandom_range(0, 3) != 0);
          run_left = rdy_lvl ? $urandom_range(1, 30) : $urandom_range(1, 6);
        end
        run_left--;
        out_ready_i <= rdy_lvl;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", idle_cycles);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned ep;
    int unsigned dir_beats;
    tmr = '{ctrl: '0, period: '0, count: '0, presc: 0, restart: 1'b0};
    dir_rows = '{
      '{ptp_pkg::ACT_READ,  ptp_pkg::SEL_CTRL,   32'h0,         8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_READ,  ptp_pkg::SEL_PERIOD, 32'h0,         8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_READ,  ptp_pkg::SEL_COUNT,  32'hFFFF_FFFF, 8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_READ,  SEL_UNUSED,          32'h0,         8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_TICK,  ptp_pkg::SEL_CTRL,   32'h0,         8'd1, 1'b1, 32'h0,   1'b0},
      '{ACT_UNUSED,         ptp_pkg::SEL_CTRL,   32'hFFFF_FFFF, 8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_WRITE, SEL_UNUSED,          32'hFFFF_FFFF, 8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_WRITE, ptp_pkg::SEL_PERIOD, 32'hFFFF_FFFF, 8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_READ,  ptp_pkg::SEL_PERIOD, 32'h0, 8'd1, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{ptp_pkg::ACT_WRITE, ptp_pkg::SEL_CTRL,   32'hFFFF_FFFF, 8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_READ,  ptp_pkg::SEL_CTRL,   32'h0, 8'd1, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{ptp_pkg::ACT_TICK,  ptp_pkg::SEL_COUNT,  32'h0,         8'd1, 1'b0, 32'h0,   1'b0},
      '{ptp_pkg::ACT_READ,  ptp_pkg::SEL_CTRL,   32'h0, 8'd1, 1'b1, 32'hFFFF_FFBF, 1'b0},
      '{ptp_pkg::ACT_WRITE, ptp_pkg::SEL_CTRL,   32'h0,         8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_TICK,  ptp_pkg::SEL_CTRL,   32'h0,         8'd1, 1'b0, 32'h0,   1'b0},
      '{ptp_pkg::ACT_WRITE, ptp_pkg::SEL_COUNT,  32'h0001_2345, 8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_WRITE, ptp_pkg::SEL_CTRL,   32'h0000_0080, 8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_TICK,  ptp_pkg::SEL_CTRL,   32'h0,         8'd1, 1'b0, 32'h0,   1'b0},
      '{ptp_pkg::ACT_READ,  ptp_pkg::SEL_COUNT,  32'h0,         8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_WRITE, ptp_pkg::SEL_COUNT,  32'hFFFF_FFFF, 8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_WRITE, ptp_pkg::SEL_PERIOD, 32'h0,         8'd1, 1'b1, 32'h0,   1'b0},
      '{ptp_pkg::ACT_TICK,  ptp_pkg::SEL_CTRL,   32'h0,         8'd7, 1'b0, 32'h0,   1'b0},
      '{ptp_pkg::ACT_READ,  ptp_pkg::SEL_COUNT,  32'h0,         8'd1, 1'b0, 32'h0,   1'b0}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      repeat (dir_rows[i].reps) send_beat(dir_rows[i].act, dir_rows[i].sel, dir_rows[i].data,
                                          dir_rows[i].typed, dir_rows[i].rd, dir_rows[i].ev);
    end
    dir_beats = all_beats;

    ep = 0;
    while (live_beats < dir_beats + RANDOM_BEATS) begin
      if (ep == 4 || ep == 14) hold_req++;
      if (ep == 9) begin
        in_valid_i <= 1'b0;
        burst_left = 0;
        do @(posedge clk_i); while (due_out_q.size() != 0);
      end
      run_episode();
      ep++;
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_out_q.size() != 0);
    repeat (10) @(posedge clk_i);

    $display("%0d beats sent (%0d directed) over %0d timer episodes", all_beats, dir_beats, ep);
    $display("%0d results checked, %0d period events, %0d errors", checked, events_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
